[sv/framed_command_sender_with_ack_retry_defines.svh]
// Assertion macros used by the checker of the command sender.
`ifndef FRAMED_COMMAND_SENDER_WITH_ACK_RETRY_DEFINES_SVH
`define FRAMED_COMMAND_SENDER_WITH_ACK_RETRY_DEFINES_SVH

// Clocked check, switched off while reset is asserted
`define FCS_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define FCS_CHK_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/fcs_pkg.sv]
package fcs_pkg;

	// default sizing
	localparam int WORD_COUNT_DEF = 4;
	localparam int TIMER_BITS_DEF = 16;

	// frame layout: two header bytes, sequence, device id, then the words and a checksum
	localparam int HDR_LEN = 4;
	localparam logic [7:0] HDR_BYTE = 8'hA5;

	// configuration registers
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RESEND_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = 2'd1;
	localparam logic [CFG_W-1:0] RESEND_INTERVAL_RST = 16'd10;
	localparam logic [CFG_W-1:0] MAX_WAIT_RST = 16'd100;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_RX_BYTE  = 2'd1,
		OP_SEND     = 2'd2,
		OP_SEND_ACK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	// launch request from control to the serializer
	typedef struct packed {
		logic  frame;
		logic  status;
		kind_t kind;
	} ser_req_t;

endpackage

[sv/fcs_ctrl.sv]
module fcs_ctrl import fcs_pkg::*; #(
	parameter int WORD_COUNT = WORD_COUNT_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_idx,
	input  logic [CFG_W-1:0]          cfg_wdata,
	input  logic                      item_valid,
	input  op_t                       op,
	input  logic [7:0]                dev,
	input  logic [32*WORD_COUNT-1:0]  words,
	input  logic [7:0]                rx,
	input  logic                      ser_free,
	output logic                      item_take,
	output ser_req_t                  req,
	output logic [7:0]                seq,
	output logic [7:0]                held_dev,
	output logic [32*WORD_COUNT-1:0]  held_words
);

	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic [CFG_W-1:0]         resend_q, max_wait_q;
	logic [7:0]               seq_q, seq_d;
	logic                     wait_q, wait_d;
	logic [TIMER_BITS-1:0]    t_start_q, t_start_d, t_send_q, t_send_d;
	logic [TIMER_BITS-1:0]    t_start_inc, t_send_inc;
	logic [7:0]               held_dev_q;
	logic [32*WORD_COUNT-1:0] held_words_q;
	logic                     hold_we;
	logic                     start_over, send_over;

	// saturating tick counters and limit compares
	assign t_start_inc = (&t_start_q) ? t_start_q : t_start_q + TIMER_BITS'(1);
	assign t_send_inc  = (&t_send_q) ? t_send_q : t_send_q + TIMER_BITS'(1);
	assign start_over  = CMP_W'(t_start_inc) > CMP_W'(max_wait_q);
	assign send_over   = CMP_W'(t_send_inc) > CMP_W'(resend_q);

	// one item is taken only when its result can be launched
	assign item_take = item_valid && ser_free;

	// item decode and state update
	always_comb begin
		seq_d     = seq_q;
		wait_d    = wait_q;
		t_start_d = t_start_q;
		t_send_d  = t_send_q;
		hold_we   = 1'b0;
		req       = '0;
		req.kind  = KIND_BYTE;
		if (item_take) begin
			case (op)
				OP_TICK: begin
					if (wait_q) begin
						t_start_d = t_start_inc;
						t_send_d  = t_send_inc;
						if (start_over) begin
							wait_d     = 1'b0;
							req.status = 1'b1;
							req.kind   = KIND_TIMEOUT;
						end else if (send_over) begin
							t_send_d  = '0;
							seq_d     = seq_q + 8'd1;
							req.frame = 1'b1;
						end
					end
				end
				OP_RX_BYTE: begin
					if (wait_q && rx == seq_q) begin
						wait_d     = 1'b0;
						req.status = 1'b1;
						req.kind   = KIND_ACK;
					end
				end
				OP_SEND, OP_SEND_ACK: begin
					if (!wait_q) begin
						hold_we   = 1'b1;
						seq_d     = seq_q + 8'd1;
						req.frame = 1'b1;
						if (op == OP_SEND_ACK) begin
							wait_d    = 1'b1;
							t_start_d = '0;
							t_send_d  = '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// control state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= '0;
			wait_q     <= 1'b0;
			t_start_q  <= '0;
			t_send_q   <= '0;
			resend_q   <= RESEND_INTERVAL_RST;
			max_wait_q <= MAX_WAIT_RST;
		end else begin
			seq_q     <= seq_d;
			wait_q    <= wait_d;
			t_start_q <= t_start_d;
			t_send_q  <= t_send_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RESEND_INTERVAL: resend_q   <= cfg_wdata;
					CFG_MAX_WAIT:        max_wait_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// held command for resends
	always_ff @(posedge clk) begin
		if (hold_we) begin
			held_dev_q   <= dev;
			held_words_q <= words;
		end
	end

	assign seq        = seq_q;
	assign held_dev   = held_dev_q;
	assign held_words = held_words_q;

endmodule

[sv/fcs_ser.sv]
module fcs_ser import fcs_pkg::*; #(
	parameter int WORD_COUNT = WORD_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ser_req_t                  req,
	input  logic [7:0]                seq,
	input  logic [7:0]                dev,
	input  logic [32*WORD_COUNT-1:0]  words,
	output logic                      free,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);

	localparam int FRAME_LEN = HDR_LEN + 4 * WORD_COUNT + 1;
	localparam int IDX_W = $clog2(FRAME_LEN);
	localparam int BYTE_W = $clog2(4 * WORD_COUNT);
	localparam logic [IDX_W-1:0] IDX_HDR1  = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_SEQ   = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_DEV   = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_WORD0 = IDX_W'(HDR_LEN);
	localparam logic [IDX_W-1:0] IDX_SUM   = IDX_W'(FRAME_LEN - 1);

	logic [4*WORD_COUNT-1:0][7:0] word_bytes;
	logic             busy_q, valid_q, last_q;
	logic [IDX_W-1:0] idx_q, word_off;
	logic [7:0]       sum_q, byte_q, cur_byte;
	kind_t            kind_q;
	logic             ld, in_sum;

	assign word_bytes = words;
	assign ld   = !valid_q || m_tready;
	assign free = !busy_q && ld;

	// byte select for the current frame position
	assign word_off = idx_q - IDX_WORD0;
	assign in_sum   = (idx_q >= IDX_SEQ) && (idx_q != IDX_SUM);
	always_comb begin
		if (idx_q == IDX_SEQ) begin
			cur_byte = seq;
		end else if (idx_q == IDX_DEV) begin
			cur_byte = dev;
		end else if (idx_q == IDX_SUM) begin
			cur_byte = sum_q;
		end else if (idx_q >= IDX_WORD0) begin
			cur_byte = word_bytes[word_off[BYTE_W-1:0]];
		end else begin
			cur_byte = HDR_BYTE;
		end
	end

	// output valid and frame busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (busy_q && ld) begin
			valid_q <= 1'b1;
			if (idx_q == IDX_SUM) begin
				busy_q <= 1'b0;
			end
		end else if (req.frame) begin
			valid_q <= 1'b1;
			busy_q  <= 1'b1;
		end else if (req.status) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// result register, position counter and running checksum
	always_ff @(posedge clk) begin
		if (busy_q && ld) begin
			byte_q <= cur_byte;
			kind_q <= KIND_BYTE;
			last_q <= (idx_q == IDX_SUM);
			idx_q  <= idx_q + IDX_W'(1);
			if (in_sum) begin
				sum_q <= sum_q + cur_byte;
			end
		end else if (req.frame) begin
			// first header byte goes out on launch
			byte_q <= HDR_BYTE;
			kind_q <= KIND_BYTE;
			last_q <= 1'b0;
			idx_q  <= IDX_HDR1;
			sum_q  <= '0;
		end else if (req.status) begin
			byte_q <= '0;
			kind_q <= req.kind;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

[sv/framed_command_sender_with_ack_retry.sv]
// Command frame sender with acknowledge and retransmit.
// Input stream (s_*): one request per item; tuser carries the operation
// (tick, received byte, send once, send awaiting acknowledge), tdata the
// device id, the command words and the received byte.
// Output stream (m_*): the results of each item; tuser carries the kind (frame
// byte, acknowledge, timeout), tdata the frame byte, tlast marks the final
// frame byte and every status result.
// Configuration channel (cfg_*): index 0 resend interval, index 1 maximum
// wait, both in ticks; writes are taken in any cycle and should be done
// while the block is idle.
// The first result of a request passes the input register and the result
// register. A send occupies the serializer for 4*WORD_COUNT+5 bytes (21
// at four words), one byte per cycle while the receiver does not stall;
// ticks or bytes that give no result are taken one per cycle. The frame
// serializer sets the rate: a new request is taken only when it is free.
// Reset clears the sequence number, the wait flag and both timers, and
// loads the register defaults (10 and 100). When the receiver stalls, the
// result register holds, the serializer waits, and the input register
// fills and then drops s_tready.
module framed_command_sender_with_ack_retry import fcs_pkg::*; #(
	parameter int WORD_COUNT = WORD_COUNT_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// dev_id[7:0], cmd_word0..cmd_word(N-1) 32 bits each, rx_byte[7:0]
	input  logic [32*WORD_COUNT+15:0]    s_tdata,
	// op[1:0]
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// tx_byte[7:0]
	output logic [7:0]                   m_tdata,
	// kind[1:0]
	output logic [1:0]                   m_tuser,
	output logic                         m_tlast,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data
);

	localparam int WORDS_W = 32 * WORD_COUNT;

	logic               valid_s1;
	op_t                op_s1;
	logic [7:0]         dev_s1, rx_s1;
	logic [WORDS_W-1:0] words_s1;
	logic               take, ser_free;
	ser_req_t           req;
	logic [7:0]         seq, held_dev;
	logic [WORDS_W-1:0] held_words;

	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_s1 || take;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= op_t'(s_tuser);
			dev_s1   <= s_tdata[7:0];
			words_s1 <= s_tdata[8 +: WORDS_W];
			rx_s1    <= s_tdata[8 + WORDS_W +: 8];
		end
	end

	fcs_ctrl #(
		.WORD_COUNT (WORD_COUNT),
		.TIMER_BITS (TIMER_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.item_valid (valid_s1),
		.op         (op_s1),
		.dev        (dev_s1),
		.words      (words_s1),
		.rx         (rx_s1),
		.ser_free   (ser_free),
		.item_take  (take),
		.req        (req),
		.seq        (seq),
		.held_dev   (held_dev),
		.held_words (held_words)
	);

	fcs_ser #(
		.WORD_COUNT (WORD_COUNT)
	) u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.seq      (seq),
		.dev      (held_dev),
		.words    (held_words),
		.free     (ser_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[sv/fcs_checker.sv]
`include "framed_command_sender_with_ack_retry_defines.svh"

module fcs_checker import fcs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// status results are single-item, with a zero byte
	`FCS_CHK(a_status_shape, m_tvalid && m_tuser != KIND_BYTE |-> m_tlast && m_tdata == 8'd0, "status result malformed")

	// a frame is never cut short by a status
	`FCS_CHK(a_frame_whole, m_tvalid && m_tready && m_tuser == KIND_BYTE && !m_tlast |=> m_tvalid && m_tuser == KIND_BYTE, "frame interrupted")

	// stalled result holds
	`FCS_CHK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// nothing offered during reset
	`FCS_CHK_RST(a_rst_quiet, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind framed_command_sender_with_ack_retry fcs_checker u_fcs_checker (.*);

[dv/tb_top.sv]
module tb_top;
	import fcs_pkg::*;

	localparam int FRAME_LEN = HDR_LEN + 4 * WORD_COUNT_DEF + 1;
	localparam int SETTLE = 40;
	localparam int LIMIT = 3_000_000;
	localparam int PHASE_ITEMS = 32;

	// Predicts the results of every accepted request and checks them in order.
	class frame_predictor;
		typedef struct packed {
			kind_t      kind;
			logic [7:0] tx;
			logic       fin;
		} due_t;

		due_t        due_q[$];
		logic [15:0] resend_ival;
		logic [15:0] wait_limit;
		logic [7:0]  seq_num;
		logic        waiting;
		logic [15:0] t_start;
		logic [15:0] t_send;
		logic [7:0]  dev_hold;
		logic [3:0][31:0] word_hold;
		int          errors, results_seen, frames, retries, acks, timeouts;

		function new();
			resend_ival = RESEND_INTERVAL_RST;
			wait_limit = MAX_WAIT_RST;
			seq_num = '0;
			waiting = 1'b0;
			t_start = '0;
			t_send = '0;
			dev_hold = '0;
			word_hold = '0;
			errors = 0;
			results_seen = 0;
			frames = 0;
			retries = 0;
			acks = 0;
			timeouts = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_RESEND_INTERVAL)
				resend_ival = val;
			else if (idx == CFG_MAX_WAIT)
				wait_limit = val;
		endfunction

		// timers stop at all ones
		function logic [15:0] bump(logic [15:0] t);
			return (t == 16'hFFFF) ? t : t + 16'd1;
		endfunction

		function void push_status(kind_t k);
			due_t d;
			d.kind = k;
			d.tx = 8'h00;
			d.fin = 1'b1;
			due_q.push_back(d);
		endfunction

		// new sequence number, then header, id, words low byte first, checksum
		function void push_frame();
			logic [7:0] fb [FRAME_LEN];
			logic [7:0] sum;
			due_t d;
			seq_num = seq_num + 8'd1;
			fb[0] = HDR_BYTE;
			fb[1] = HDR_BYTE;
			fb[2] = seq_num;
			fb[3] = dev_hold;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					fb[HDR_LEN + 4 * i + j] = word_hold[i][8 * j +: 8];
			sum = '0;
			for (int i = 2; i < FRAME_LEN - 1; i++)
				sum = sum + fb[i];
			fb[FRAME_LEN - 1] = sum;
			for (int i = 0; i < FRAME_LEN; i++) begin
				d.kind = KIND_BYTE;
				d.tx = fb[i];
				d.fin = (i == FRAME_LEN - 1);
				due_q.push_back(d);
			end
			frames++;
		endfunction

		// returns 1 when the request did something
		function bit note_request(op_t op, logic [7:0] dev, logic [3:0][31:0] words,
				logic [7:0] rx);
			case (op)
				OP_TICK: begin
					if (!waiting)
						return 0;
					t_start = bump(t_start);
					t_send = bump(t_send);
					// timeout takes priority over a resend on the same tick
					if (t_start > wait_limit) begin
						waiting = 1'b0;
						push_status(KIND_TIMEOUT);
						timeouts++;
					end else if (t_send > resend_ival) begin
						t_send = '0;
						push_frame();
						retries++;
					end
					return 1;
				end
				OP_RX_BYTE: begin
					if (waiting && rx == seq_num) begin
						waiting = 1'b0;
						push_status(KIND_ACK);
						acks++;
						return 1;
					end
					return 0;
				end
				default: begin
					if (waiting)
						return 0;
					dev_hold = dev;
					word_hold = words;
					if (op == OP_SEND_ACK) begin
						waiting = 1'b1;
						t_start = '0;
						t_send = '0;
					end
					push_frame();
					return 1;
				end
			endcase
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] tx, logic fin);
			due_t d;
			results_seen++;
			if (due_q.size() == 0) begin
				$display("%0t ERROR: expected no result, got kind/tx/last %0d/%02h/%0d",
					$time, kind, tx, fin);
				errors++;
				return;
			end
			d = due_q.pop_front();
			if (kind !== d.kind || tx !== d.tx || fin !== d.fin) begin
				$display("%0t ERROR: expected kind/tx/last %0d/%02h/%0d, got %0d/%02h/%0d",
					$time, d.kind, d.tx, d.fin, kind, tx, fin);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [32*WORD_COUNT_DEF+15:0] s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	frame_predictor sb = new();
	bit calm;
	int effective;
	int sent;

	framed_command_sender_with_ack_retry dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly no gap, some short, a few long
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [3:0][31:0] rand_words();
		logic [3:0][31:0] w;
		for (int i = 0; i < 4; i++)
			case ($urandom_range(0, 7))
				0: w[i] = '0;
				1: w[i] = '1;
				default: w[i] = $urandom;
			endcase
		return w;
	endfunction

	// one request on the input stream, then a random gap
	task automatic send_item(op_t op, logic [7:0] dev, logic [3:0][31:0] words,
			logic [7:0] rx);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		// rx_byte, cmd_word3..cmd_word0, dev_id
		s_tdata <= {rx, words, dev};
		do @(posedge clk); while (!s_tready);
		sent++;
		if (sb.note_request(op, dev, words, rx))
			effective++;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic tick();
		send_item(OP_TICK, 8'($urandom), rand_words(), 8'($urandom));
	endtask

	task automatic rx_byte(logic [7:0] b);
		send_item(OP_RX_BYTE, 8'($urandom), rand_words(), b);
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_W-1:0] ri, logic [CFG_W-1:0] mw);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_RESEND_INTERVAL;
		cfg_data <= ri;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(CFG_RESEND_INTERVAL, ri);
		cfg_index <= CFG_MAX_WAIT;
		cfg_data <= mw;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(CFG_MAX_WAIT, mw);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: check each accepted result, stall at random, one long hold
	initial begin : result_sink
		int stall;
		int hold;
		bit held;
		stall = 0;
		hold = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata, m_tlast);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!held && sb.results_seen >= 30) begin
				held = 1'b1;
				hold = 300;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				stall = idle_len();
				m_tready <= (stall == 0);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** framed_command_sender_with_ack_retry: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_W-1:0] ri_set [6];
		logic [CFG_W-1:0] mw_set [6];
		int start_cnt;
		int steps;
		int r;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= OP_TICK;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_RESEND_INTERVAL;
		cfg_data <= '0;
		calm = 1'b0;
		effective = 0;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, ignored requests, one resend, acknowledge
		send_item(OP_SEND, 8'h00, '0, 8'h00);
		send_item(OP_SEND, 8'hFF, '1, 8'hFF);
		tick();
		rx_byte(sb.seq_num);
		send_item(OP_SEND_ACK, 8'h5A, rand_words(), 8'h00);
		send_item(OP_SEND, 8'($urandom), rand_words(), 8'($urandom));
		send_item(OP_SEND_ACK, 8'($urandom), rand_words(), 8'($urandom));
		rx_byte(sb.seq_num + 8'd1);
		repeat (11) tick();
		rx_byte(sb.seq_num);

		// timeout and resend due on the same tick
		configure(16'd5, 16'd5);
		send_item(OP_SEND_ACK, 8'($urandom), rand_words(), 8'($urandom));
		repeat (6) tick();

		// zero wait: first tick times out
		configure(16'd0, 16'd0);
		send_item(OP_SEND_ACK, 8'($urandom), rand_words(), 8'($urandom));
		tick();

		// random phases over several register settings
		ri_set = '{16'd10, 16'd0, 16'd3, 16'hFFFF, 16'd1, 16'($urandom_range(0, 12))};
		mw_set = '{16'd100, 16'hFFFF, 16'd30, 16'd0, 16'd8, 16'($urandom_range(4, 60))};
		for (int p = 0; p < 6; p++) begin
			configure(ri_set[p], mw_set[p]);
			calm = ($urandom_range(0, 3) == 0);
			start_cnt = sent;
			while (sent - start_cnt < PHASE_ITEMS) begin
				r = $urandom_range(0, 9);
				if (r < 7) begin
					// acknowledged send followed by ticks, stray bytes and busy sends
					send_item(OP_SEND_ACK, 8'($urandom), rand_words(), 8'($urandom));
					steps = $urandom_range(0, 12);
					repeat (steps) begin
						case ($urandom_range(0, 19))
							0, 1, 2: rx_byte(8'($urandom));
							3, 4: send_item(op_t'($urandom_range(2, 3)), 8'($urandom),
								rand_words(), 8'($urandom));
							default: tick();
						endcase
					end
					if (sb.waiting && $urandom_range(0, 9) < 6)
						rx_byte(sb.seq_num);
				end else if (r == 7) begin
					send_item(OP_SEND, 8'($urandom), rand_words(), 8'($urandom));
				end else begin
					send_item(op_t'($urandom_range(0, 3)), 8'($urandom), rand_words(),
						8'($urandom));
				end
			end
			if (sb.waiting)
				rx_byte(sb.seq_num);
		end

		drain();
		$display("Covered %0d frames (%0d resends), %0d acknowledges, %0d timeouts.",
			sb.frames, sb.retries, sb.acks, sb.timeouts);
		$display("Checked %0d results over %0d requests (%0d effective), %0d mismatches.",
			sb.results_seen, sent, effective, sb.errors);
		if (sb.errors == 0 && sb.due_q.size() == 0)
			$display("** framed_command_sender_with_ack_retry: PASSED **");
		else
			$display("** framed_command_sender_with_ack_retry: FAILED **");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/fcs_pkg.sv
sv/fcs_ctrl.sv
sv/fcs_ser.sv
sv/framed_command_sender_with_ack_retry.sv
sv/fcs_checker.sv
dv/tb_top.sv
